// ===== rtl/ckf_pkg.sv =====
// ----------------------------------------------------------------------------
// ckf_pkg
// Shared types, constants, saturating helpers and the update microprogram
// for the clock offset Kalman filter.
// ----------------------------------------------------------------------------
package ckf_pkg;

  typedef struct packed {
    logic signed [63:0] measured_offset;
    logic        [63:0] arrival_time;
    logic signed [63:0] applied_offset;
    logic signed [63:0] applied_rate;
  } ckf_in_t;

  typedef struct packed {
    logic signed [63:0] filtered_offset;
    logic signed [63:0] filtered_rate;
    logic        [1:0]  status;
  } ckf_out_t;

  localparam logic [1:0] ST_PRIMED  = 2'd0;
  localparam logic [1:0] ST_UPDATED = 2'd1;
  localparam logic [1:0] ST_NEG     = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  localparam logic [2:0] CFG_Q_OFFSET     = 3'd0;
  localparam logic [2:0] CFG_Q_RATE       = 3'd1;
  localparam logic [2:0] CFG_R_OFFSET     = 3'd2;
  localparam logic [2:0] CFG_R_RATE       = 3'd3;
  localparam logic [2:0] CFG_INITIAL_RATE = 3'd4;

  localparam logic [63:0] S64_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ONE_Q48  = 64'd281474976710656;
  localparam logic [63:0] NS_PER_S = 64'd1000000000;
  localparam logic [63:0] DT_DIV   = 64'd65536000000000;

  localparam logic [48:0] Q_OFFSET_RST = 49'd281474977;
  localparam logic [48:0] Q_RATE_RST   = 49'd28147;
  localparam logic [48:0] R_OFFSET_RST = 49'd112589990684;
  localparam logic [48:0] R_RATE_RST   = 49'd112589990684;

  // micro-op codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MD  = 2'd2;

  localparam logic [1:0] D_IV  = 2'd0;
  localparam logic [1:0] D_DT  = 2'd1;
  localparam logic [1:0] D_ONE = 2'd2;
  localparam logic [1:0] D_DET = 2'd3;

  // scratch slots (bit 5 clear)
  localparam logic [5:0] M_TA  = 6'd0;
  localparam logic [5:0] M_T4  = 6'd1;
  localparam logic [5:0] M_T5  = 6'd2;
  localparam logic [5:0] M_ZR  = 6'd3;
  localparam logic [5:0] M_X0  = 6'd4;
  localparam logic [5:0] M_X1  = 6'd5;
  localparam logic [5:0] M_P10 = 6'd6;
  localparam logic [5:0] M_P01 = 6'd7;
  localparam logic [5:0] M_P00 = 6'd8;
  localparam logic [5:0] M_P11 = 6'd9;
  localparam logic [5:0] M_S00 = 6'd10;
  localparam logic [5:0] M_S11 = 6'd11;
  localparam logic [5:0] M_PP  = 6'd12;
  localparam logic [5:0] M_K00 = 6'd13;
  localparam logic [5:0] M_K01 = 6'd14;
  localparam logic [5:0] M_K10 = 6'd15;
  localparam logic [5:0] M_K11 = 6'd16;
  localparam logic [5:0] M_E0  = 6'd17;
  localparam logic [5:0] M_E1  = 6'd18;

  // registers and constants (bit 5 set)
  localparam logic [5:0] X_MO  = 6'd32;
  localparam logic [5:0] X_AO  = 6'd33;
  localparam logic [5:0] X_AR  = 6'd34;
  localparam logic [5:0] X_IV  = 6'd35;
  localparam logic [5:0] X_EO  = 6'd36;
  localparam logic [5:0] X_ER  = 6'd37;
  localparam logic [5:0] X_P0  = 6'd38;
  localparam logic [5:0] X_P1  = 6'd39;
  localparam logic [5:0] X_P2  = 6'd40;
  localparam logic [5:0] X_P3  = 6'd41;
  localparam logic [5:0] X_LM  = 6'd42;
  localparam logic [5:0] X_QO  = 6'd43;
  localparam logic [5:0] X_QR  = 6'd44;
  localparam logic [5:0] X_RO  = 6'd45;
  localparam logic [5:0] X_RR  = 6'd46;
  localparam logic [5:0] X_NS  = 6'd47;
  localparam logic [5:0] X_ONE = 6'd48;
  localparam logic [5:0] X_DET = 6'd49;

  localparam logic [5:0] UOP_LAST = 6'd60;

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] src_a;
    logic [5:0] src_b;
    logic [1:0] dsel;
    logic [5:0] dst;
  } ckf_uop_t;

  function automatic logic [63:0] sat65(input logic [64:0] s);
    logic [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] s_add(input logic [63:0] a, input logic [63:0] b);
    return sat65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic [63:0] s_sub(input logic [63:0] a, input logic [63:0] b);
    return sat65({a[63], a} - {b[63], b});
  endfunction

  function automatic ckf_uop_t mk(input logic [1:0] op, input logic [5:0] a,
                                  input logic [5:0] b, input logic [1:0] d,
                                  input logic [5:0] dst);
    ckf_uop_t u;
    u.op    = op;
    u.src_a = a;
    u.src_b = b;
    u.dsel  = d;
    u.dst   = dst;
    return u;
  endfunction

  function automatic ckf_uop_t ckf_uop(input logic [5:0] idx);
    ckf_uop_t u;
    unique case (idx)
      6'd0:  u = mk(OP_ADD, X_LM,  X_AO,  D_ONE, M_TA);
      6'd1:  u = mk(OP_SUB, X_MO,  M_TA,  D_ONE, M_TA);
      6'd2:  u = mk(OP_MD,  M_TA,  X_NS,  D_IV,  M_ZR);
      6'd3:  u = mk(OP_MD,  X_IV,  X_ER,  D_DT,  M_TA);
      6'd4:  u = mk(OP_ADD, X_EO,  M_TA,  D_ONE, M_TA);
      6'd5:  u = mk(OP_ADD, M_TA,  X_AO,  D_ONE, M_X0);
      6'd6:  u = mk(OP_ADD, X_ER,  X_AR,  D_ONE, M_X1);
      6'd7:  u = mk(OP_MD,  X_IV,  X_P3,  D_DT,  M_TA);
      6'd8:  u = mk(OP_ADD, X_P2,  M_TA,  D_ONE, M_P10);
      6'd9:  u = mk(OP_ADD, X_P1,  M_TA,  D_ONE, M_P01);
      6'd10: u = mk(OP_MD,  X_IV,  X_P1,  D_DT,  M_TA);
      6'd11: u = mk(OP_ADD, X_P0,  M_TA,  D_ONE, M_TA);
      6'd12: u = mk(OP_MD,  X_IV,  M_P10, D_DT,  M_T4);
      6'd13: u = mk(OP_ADD, M_TA,  M_T4,  D_ONE, M_TA);
      6'd14: u = mk(OP_ADD, M_TA,  X_QO,  D_ONE, M_P00);
      6'd15: u = mk(OP_ADD, X_P3,  X_QR,  D_ONE, M_P11);
      6'd16: u = mk(OP_ADD, M_P00, X_RO,  D_ONE, M_S00);
      6'd17: u = mk(OP_ADD, M_P11, X_RR,  D_ONE, M_S11);
      6'd18: u = mk(OP_MD,  M_S00, M_S11, D_ONE, M_T5);
      6'd19: u = mk(OP_MD,  M_P01, M_P10, D_ONE, M_PP);
      6'd20: u = mk(OP_SUB, M_T5,  M_PP,  D_ONE, X_DET);
      6'd21: u = mk(OP_MD,  M_P00, M_S11, D_ONE, M_T5);
      6'd22: u = mk(OP_SUB, M_T5,  M_PP,  D_ONE, M_T5);
      6'd23: u = mk(OP_MD,  M_T5,  X_ONE, D_DET, M_K00);
      6'd24: u = mk(OP_MD,  M_P01, M_S00, D_ONE, M_T5);
      6'd25: u = mk(OP_MD,  M_P00, M_P01, D_ONE, M_T4);
      6'd26: u = mk(OP_SUB, M_T5,  M_T4,  D_ONE, M_T5);
      6'd27: u = mk(OP_MD,  M_T5,  X_ONE, D_DET, M_K01);
      6'd28: u = mk(OP_MD,  M_P10, M_S11, D_ONE, M_T5);
      6'd29: u = mk(OP_MD,  M_P11, M_P10, D_ONE, M_T4);
      6'd30: u = mk(OP_SUB, M_T5,  M_T4,  D_ONE, M_T5);
      6'd31: u = mk(OP_MD,  M_T5,  X_ONE, D_DET, M_K10);
      6'd32: u = mk(OP_MD,  M_P11, M_S00, D_ONE, M_T5);
      6'd33: u = mk(OP_SUB, M_T5,  M_PP,  D_ONE, M_T5);
      6'd34: u = mk(OP_MD,  M_T5,  X_ONE, D_DET, M_K11);
      6'd35: u = mk(OP_SUB, X_MO,  M_X0,  D_ONE, M_E0);
      6'd36: u = mk(OP_SUB, M_ZR,  M_X1,  D_ONE, M_E1);
      6'd37: u = mk(OP_MD,  M_K00, M_E0,  D_ONE, M_T5);
      6'd38: u = mk(OP_ADD, M_X0,  M_T5,  D_ONE, M_T5);
      6'd39: u = mk(OP_MD,  M_K01, M_E1,  D_ONE, M_T4);
      6'd40: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, X_EO);
      6'd41: u = mk(OP_MD,  M_K10, M_E0,  D_ONE, M_T5);
      6'd42: u = mk(OP_ADD, M_X1,  M_T5,  D_ONE, M_T5);
      6'd43: u = mk(OP_MD,  M_K11, M_E1,  D_ONE, M_T4);
      6'd44: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, X_ER);
      6'd45: u = mk(OP_MD,  M_K00, M_P00, D_ONE, M_T5);
      6'd46: u = mk(OP_MD,  M_K01, M_P10, D_ONE, M_T4);
      6'd47: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, M_T5);
      6'd48: u = mk(OP_SUB, M_P00, M_T5,  D_ONE, X_P0);
      6'd49: u = mk(OP_MD,  M_K00, M_P01, D_ONE, M_T5);
      6'd50: u = mk(OP_MD,  M_K01, M_P11, D_ONE, M_T4);
      6'd51: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, M_T5);
      6'd52: u = mk(OP_SUB, M_P01, M_T5,  D_ONE, X_P1);
      6'd53: u = mk(OP_MD,  M_K10, M_P00, D_ONE, M_T5);
      6'd54: u = mk(OP_MD,  M_K11, M_P10, D_ONE, M_T4);
      6'd55: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, M_T5);
      6'd56: u = mk(OP_SUB, M_P10, M_T5,  D_ONE, X_P2);
      6'd57: u = mk(OP_MD,  M_K10, M_P01, D_ONE, M_T5);
      6'd58: u = mk(OP_MD,  M_K11, M_P11, D_ONE, M_T4);
      6'd59: u = mk(OP_ADD, M_T5,  M_T4,  D_ONE, M_T5);
      6'd60: u = mk(OP_SUB, M_P11, M_T5,  D_ONE, X_P3);
      default: u = mk(OP_ADD, M_TA, M_TA, D_ONE, M_TA);
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/ckf_muldiv.sv =====
// ----------------------------------------------------------------------------
// ckf_muldiv
// Serial round(a*b/d): shift-add multiply, rounding, restoring divide,
// round half away from zero, saturated to signed 64 bits.
// ----------------------------------------------------------------------------
module ckf_muldiv
  import ckf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] d,
  output logic        done,
  output logic [63:0] res
);

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_MUL  = 3'd1;
  localparam logic [2:0] P_RND  = 3'd2;
  localparam logic [2:0] P_CHK  = 3'd3;
  localparam logic [2:0] P_DIV  = 3'd4;
  localparam logic [2:0] P_FIN  = 3'd5;

  logic [2:0]   ph_r, ph_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic [127:0] prod_r, prod_nxt;
  logic [63:0]  ua_r, ua_nxt;
  logic [63:0]  d_r, d_nxt;
  logic         neg_r, neg_nxt;
  logic         sat_r, sat_nxt;
  logic         zero_r, zero_nxt;

  logic [64:0]  msum;
  logic [64:0]  r2;
  logic         ge;
  logic [63:0]  q;

  always_comb begin
    msum = {1'b0, prod_r[127:64]} + {1'b0, ua_r};
    r2   = {prod_r[127:64], prod_r[63]};
    ge   = (r2 >= {1'b0, d_r});
    q    = prod_r[63:0];

    ph_nxt   = ph_r;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    ua_nxt   = ua_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    zero_nxt = zero_r;

    unique case (ph_r)
      P_IDLE: begin
        if (start) begin
          neg_nxt  = a[63] ^ b[63];
          ua_nxt   = a[63] ? 64'd0 - a : a;
          prod_nxt = {64'd0, (b[63] ? 64'd0 - b : b)};
          d_nxt    = d;
          cnt_nxt  = '0;
          sat_nxt  = 1'b0;
          zero_nxt = (d == 64'd0);
          ph_nxt   = (d == 64'd0) ? P_FIN : P_MUL;
        end
      end
      P_MUL: begin
        if (prod_r[0]) begin
          prod_nxt = {msum, prod_r[63:1]};
        end else begin
          prod_nxt = {1'b0, prod_r[127:1]};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          ph_nxt = P_RND;
        end
      end
      P_RND: begin
        prod_nxt = prod_r + {65'd0, d_r[63:1]};
        ph_nxt   = P_CHK;
      end
      P_CHK: begin
        cnt_nxt = '0;
        if (prod_r[127:64] >= d_r) begin
          sat_nxt = 1'b1;
          ph_nxt  = P_FIN;
        end else begin
          ph_nxt = P_DIV;
        end
      end
      P_DIV: begin
        if (ge) begin
          prod_nxt = {r2[63:0] - d_r, prod_r[62:0], 1'b1};
        end else begin
          prod_nxt = {r2[63:0], prod_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          ph_nxt = P_FIN;
        end
      end
      P_FIN: begin
        ph_nxt = P_IDLE;
      end
      default: begin
        ph_nxt = P_IDLE;
      end
    endcase
  end

  always_comb begin
    if (zero_r) begin
      res = 64'd0;
    end else if (sat_r) begin
      res = neg_r ? S64_MIN : S64_MAX;
    end else if (neg_r) begin
      res = (q > S64_MIN) ? S64_MIN : 64'd0 - q;
    end else begin
      res = q[63] ? S64_MAX : q;
    end
  end

  assign done = (ph_r == P_FIN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    ua_r   <= ua_nxt;
    d_r    <= d_nxt;
    neg_r  <= neg_nxt;
    sat_r  <= sat_nxt;
    zero_r <= zero_nxt;
  end

endmodule

// ===== rtl/clock_offset_kalman_filter.sv =====
// Sequence: a priming or restarting transaction passes through states IV1 and IV2
// to DONE. An update runs 61 micro-ops: 32 add or subtract steps through states RA,
// RB, RC and EX, and 29 serial multiply-divides that also wait in MW.
// One transaction at a time: the input stalls until the result is registered.
// Synchronous active-low reset sets the default noise registers, zero estimates
// and identity covariance.
// ----------------------------------------------------------------------------
// clock_offset_kalman_filter
// Two-state offset/rate Kalman filter sequenced over one shared
// multiply-divide unit and one saturating adder.
// ----------------------------------------------------------------------------
module clock_offset_kalman_filter
  import ckf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  ckf_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output ckf_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IV1  = 4'd1;
  localparam logic [3:0] S_IV2  = 4'd2;
  localparam logic [3:0] S_RA   = 4'd3;
  localparam logic [3:0] S_RB   = 4'd4;
  localparam logic [3:0] S_RC   = 4'd5;
  localparam logic [3:0] S_EX   = 4'd6;
  localparam logic [3:0] S_MW   = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]  st_r;
  logic [5:0]  idx_r;
  ckf_in_t     in_r;
  logic [63:0] diff_r;
  logic [63:0] iv_r;
  logic [1:0]  status_r;
  logic        phase_r;

  logic [48:0] q_offset_r, q_rate_r, r_offset_r, r_rate_r;
  logic [63:0] initial_rate_r;
  logic [63:0] est_offset_r, est_rate_r, last_meas_r, last_arr_r, det_r;
  logic [63:0] p0_r, p1_r, p2_r, p3_r;

  logic [63:0] tmp_mem [32];
  logic [63:0] rd_r;
  logic [4:0]  rd_addr;

  logic [63:0] opa_r, opb_r;
  logic        out_valid_r;
  ckf_out_t    out_r;

  ckf_uop_t    uop;
  logic        det_pos;
  logic [63:0] iv_shift, iv_val, alu_res, md_d, md_res, wb_val;
  logic        wb_en, md_start, md_done;

  function automatic logic [63:0] pick(input logic [5:0] code, input logic [63:0] mdat,
                                       input logic [63:0] mo, input logic [63:0] ao,
                                       input logic [63:0] ar, input logic [63:0] iv,
                                       input logic [63:0] eo, input logic [63:0] er,
                                       input logic [63:0] p0, input logic [63:0] p1,
                                       input logic [63:0] p2, input logic [63:0] p3,
                                       input logic [63:0] lm, input logic [48:0] qo,
                                       input logic [48:0] qr, input logic [48:0] ro,
                                       input logic [48:0] rr);
    logic [63:0] v;
    if (!code[5]) begin
      v = mdat;
    end else begin
      unique case (code)
        X_MO:    v = mo;
        X_AO:    v = ao;
        X_AR:    v = ar;
        X_IV:    v = iv;
        X_EO:    v = eo;
        X_ER:    v = er;
        X_P0:    v = p0;
        X_P1:    v = p1;
        X_P2:    v = p2;
        X_P3:    v = p3;
        X_LM:    v = lm;
        X_QO:    v = {15'd0, qo};
        X_QR:    v = {15'd0, qr};
        X_RO:    v = {15'd0, ro};
        X_RR:    v = {15'd0, rr};
        X_NS:    v = NS_PER_S;
        X_ONE:   v = ONE_Q48;
        default: v = 64'd0;
      endcase
    end
    return v;
  endfunction

  logic [63:0] pick_val;
  logic [5:0]  pick_code;

  assign uop       = ckf_uop(idx_r);
  assign det_pos   = !det_r[63] && (det_r != 64'd0);
  assign pick_code = (st_r == S_RB) ? uop.src_a : uop.src_b;
  assign pick_val  = pick(pick_code, rd_r, in_r.measured_offset, in_r.applied_offset,
                          in_r.applied_rate, iv_r, est_offset_r, est_rate_r,
                          p0_r, p1_r, p2_r, p3_r, last_meas_r,
                          q_offset_r, q_rate_r, r_offset_r, r_rate_r);

  always_comb begin
    if ($signed(diff_r) > $signed(S64_MAX >> 16)) begin
      iv_shift = S64_MAX;
    end else if ($signed(diff_r) < -$signed(64'd140737488355328)) begin
      iv_shift = S64_MIN;
    end else begin
      iv_shift = {diff_r[47:0], 16'd0};
    end
    iv_val = s_sub(iv_shift, in_r.applied_offset);
  end

  always_comb begin
    rd_addr = (st_r == S_RA) ? uop.src_a[4:0] : uop.src_b[4:0];
    alu_res = (uop.op == OP_SUB) ? s_sub(opa_r, opb_r) : s_add(opa_r, opb_r);
    unique case (uop.dsel)
      D_IV:    md_d = iv_r;
      D_DT:    md_d = DT_DIV;
      D_ONE:   md_d = ONE_Q48;
      D_DET:   md_d = det_r;
      default: md_d = ONE_Q48;
    endcase
    md_start = (st_r == S_EX) && (uop.op == OP_MD);
    wb_en    = ((st_r == S_EX) && (uop.op != OP_MD)) || ((st_r == S_MW) && md_done);
    if (st_r == S_MW) begin
      wb_val = ((uop.dsel == D_DET) && !det_pos) ? 64'd0 : md_res;
    end else begin
      wb_val = alu_res;
    end
  end

  ckf_muldiv u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (opa_r),
    .b     (opb_r),
    .d     (md_d),
    .done  (md_done),
    .res   (md_res)
  );

  always_ff @(posedge clk) begin
    rd_r <= tmp_mem[rd_addr];
    if (wb_en && !uop.dst[5]) begin
      tmp_mem[uop.dst[4:0]] <= wb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_RB) begin
      opa_r <= pick_val;
    end
    if (st_r == S_RC) begin
      opb_r <= pick_val;
    end
    if (st_r == S_IDLE && in_valid) begin
      in_r <= in_data;
    end
    if (st_r == S_IV1) begin
      diff_r <= in_r.arrival_time - last_arr_r;
    end
    if (st_r == S_IV2) begin
      iv_r <= iv_val;
    end
    if (st_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r.filtered_offset <= (status_r[1]) ? 64'd0 : est_offset_r;
      out_r.filtered_rate   <= est_rate_r;
      out_r.status          <= status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r           <= S_IDLE;
      idx_r          <= '0;
      status_r       <= ST_PRIMED;
      phase_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      q_offset_r     <= Q_OFFSET_RST;
      q_rate_r       <= Q_RATE_RST;
      r_offset_r     <= R_OFFSET_RST;
      r_rate_r       <= R_RATE_RST;
      initial_rate_r <= 64'd0;
      est_offset_r   <= 64'd0;
      est_rate_r     <= 64'd0;
      last_meas_r    <= 64'd0;
      last_arr_r     <= 64'd0;
      det_r          <= 64'd0;
      p0_r           <= ONE_Q48;
      p1_r           <= 64'd0;
      p2_r           <= 64'd0;
      p3_r           <= ONE_Q48;
    end else begin
      if (out_valid_r && !out_stall && st_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            st_r <= S_IV1;
          end
        end
        S_IV1: begin
          st_r <= S_IV2;
        end
        S_IV2: begin
          if (!phase_r) begin
            phase_r      <= 1'b1;
            est_offset_r <= in_r.measured_offset;
            status_r     <= ST_PRIMED;
            st_r         <= S_DONE;
          end else if (iv_val[63] || iv_val == 64'd0) begin
            phase_r  <= 1'b0;
            status_r <= iv_val[63] ? ST_NEG : ST_ZERO;
            st_r     <= S_DONE;
          end else begin
            status_r <= ST_UPDATED;
            idx_r    <= '0;
            st_r     <= S_RA;
          end
        end
        S_RA: st_r <= S_RB;
        S_RB: st_r <= S_RC;
        S_RC: st_r <= S_EX;
        S_EX, S_MW: begin
          if (md_start) begin
            st_r <= S_MW;
          end else if (wb_en) begin
            if (idx_r == UOP_LAST) begin
              st_r <= S_DONE;
            end else begin
              idx_r <= idx_r + 6'd1;
              st_r  <= S_RA;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            if (!status_r[1]) begin
              last_meas_r <= in_r.measured_offset;
              last_arr_r  <= in_r.arrival_time;
            end
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
      if (wb_en && uop.dst[5]) begin
        unique case (uop.dst)
          X_EO:    est_offset_r <= wb_val;
          X_ER:    est_rate_r   <= wb_val;
          X_P0:    p0_r         <= wb_val;
          X_P1:    p1_r         <= wb_val;
          X_P2:    p2_r         <= wb_val;
          X_P3:    p3_r         <= wb_val;
          X_DET:   det_r        <= wb_val;
          default: det_r        <= det_r;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_Q_OFFSET: q_offset_r <= cfg_data[48:0];
          CFG_Q_RATE:   q_rate_r   <= cfg_data[48:0];
          CFG_R_OFFSET: r_offset_r <= cfg_data[48:0];
          CFG_R_RATE:   r_rate_r   <= cfg_data[48:0];
          CFG_INITIAL_RATE: begin
            initial_rate_r <= cfg_data;
            est_rate_r     <= cfg_data;
          end
          default: initial_rate_r <= initial_rate_r;
        endcase
      end
    end
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = (st_r == S_IDLE);

`ifndef SYNTHESIS
  a_md_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> st_r == S_MW)
    else $error("multiply-divide finished outside wait state");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == S_DONE)
    else $error("result raised without a finished transaction");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= UOP_LAST)
    else $error("micro-op index out of range");

  a_update_needs_iv: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RA && idx_r == 6'd0) |-> (!iv_r[63] && iv_r != 64'd0))
    else $error("update started on a non-positive interval");
`endif

endmodule
